// ----- src/fpa_pkg.sv -----
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int unsigned Precision = 10;
  localparam int unsigned FracBits  = Precision - 1;
  localparam int unsigned DivBits   = 64;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = 2;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_SUB     = 3'd1,
    CMD_FIXMUL  = 3'd2,
    CMD_FIXDIV  = 3'd3,
    CMD_INTMUL  = 3'd4,
    CMD_INTDIV  = 3'd5,
    CMD_NEGATE  = 3'd6,
    CMD_COMPARE = 3'd7
  } cmd_t;

  // classified item handed from front to back
  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               dz;
  } item_t;

  typedef struct packed {
    logic signed [31:0] res;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               dz;
  } res_t;

endpackage

// ----- src/fpa_front.sv -----
`timescale 1ns / 1ps
module fpa_front import fpa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_a,
  input  logic signed [31:0] in_b,
  output logic               q_valid,
  input  logic               q_ready,
  output item_t              q_item
);

  item_t             mem [QDepth];
  logic [QPtrW:0]    wptr, rptr;
  logic              is_div;
  item_t             cls;

  always_comb begin
    is_div     = (in_cmd == CMD_FIXDIV) || (in_cmd == CMD_INTDIV);
    cls.cmd    = cmd_t'(in_cmd);
    cls.a      = in_a;
    cls.b      = in_b;
    cls.lt     = in_a < in_b;
    cls.eq     = in_a == in_b;
    cls.gt     = in_a > in_b;
    cls.dz     = is_div && (in_b == 32'sd0);
  end

  assign in_ready = (wptr - rptr) != QDepth[QPtrW:0];
  assign q_valid  = wptr != rptr;
  assign q_item   = mem[rptr[QPtrW-1:0]];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wptr[QPtrW-1:0]] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (in_valid && in_ready) wptr <= wptr + 1'b1;
      if (q_valid && q_ready)   rptr <= rptr + 1'b1;
    end
  end

  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot({cls.lt, cls.eq, cls.gt})) else $error("compare flags not one-hot");
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (wptr - rptr) <= QDepth[QPtrW:0]) else $error("queue overfilled");
  a_empty_gap: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> in_ready) else $error("empty queue refused word");

endmodule

// ----- src/fpa_back.sv -----
`timescale 1ns / 1ps
module fpa_back import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  output logic  q_ready,
  input  item_t q_item,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int unsigned NStage = DivBits + 2;

  // stage 0 captures operands; divider runs one quotient bit a stage;
  // last stage selects the result.
  logic              vld   [NStage];
  item_t             it    [DivBits+1];
  logic [63:0]       rem   [DivBits+1];
  logic [63:0]       quo   [DivBits+1];
  logic [63:0]       dvs   [DivBits+1];
  logic              qneg  [DivBits+1];
  logic signed [63:0] prod [DivBits+1];

  logic adv;
  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  logic [63:0] num0, den0;
  logic signed [63:0] asx, bsx;
  always_comb begin
    asx  = 64'(q_item.a);
    bsx  = 64'(q_item.b);
    if (q_item.cmd == CMD_FIXDIV) num0 = asx <<< FracBits;
    else                          num0 = asx;
    den0 = bsx;
    if (num0[63]) num0 = -num0;
    if (den0[63]) den0 = -den0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NStage; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= q_valid;
      for (int i = 1; i < NStage; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it[0]   <= q_item;
      rem[0]  <= '0;
      quo[0]  <= num0;
      dvs[0]  <= den0;
      qneg[0] <= q_item.a[31] ^ q_item.b[31];
      prod[0] <= asx * bsx;
    end
  end

  // restoring divide, one bit per stage
  for (genvar s = 1; s <= DivBits; s++) begin : g_div
    logic [64:0] r_sh, diff;
    always_comb begin
      r_sh = {rem[s-1], quo[s-1][63]};
      diff = r_sh - {1'b0, dvs[s-1]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        it[s]   <= it[s-1];
        dvs[s]  <= dvs[s-1];
        qneg[s] <= qneg[s-1];
        prod[s] <= prod[s-1];
        if (!diff[64]) begin
          rem[s] <= diff[63:0];
          quo[s] <= {quo[s-1][62:0], 1'b1};
        end else begin
          rem[s] <= r_sh[63:0];
          quo[s] <= {quo[s-1][62:0], 1'b0};
        end
      end
    end
  end

  logic [63:0] q_fin;
  logic signed [63:0] p_sh;
  res_t sel;
  always_comb begin
    q_fin = qneg[DivBits] ? -quo[DivBits] : quo[DivBits];
    p_sh  = prod[DivBits] >>> FracBits;
    sel.lt = it[DivBits].lt;
    sel.eq = it[DivBits].eq;
    sel.gt = it[DivBits].gt;
    sel.dz = it[DivBits].dz;
    case (it[DivBits].cmd)
      CMD_ADD:    sel.res = it[DivBits].a + it[DivBits].b;
      CMD_SUB:    sel.res = it[DivBits].a - it[DivBits].b;
      CMD_FIXMUL: sel.res = p_sh[31:0];
      CMD_INTMUL: sel.res = prod[DivBits][31:0];
      CMD_FIXDIV, CMD_INTDIV:
        sel.res = it[DivBits].dz ? 32'sd0 : q_fin[31:0];
      CMD_NEGATE: sel.res = -it[DivBits].a;
      default:    sel.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= sel;
    end
  end
  assign out_valid = vld[NStage-1];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_res)) else $error("result moved while stalled");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.dz |-> out_res.res == 32'sd0) else $error("divide by zero result");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({out_res.lt, out_res.eq, out_res.gt})) else $error("flags");

endmodule

// ----- src/fixed_point_alu.sv -----
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                          | tuser
// s_axis  | in  | command[2:0] a[34:3] b[66:35], pad to 72     | -
// m_axis  | out | result[31:0] lt[32] eq[33] gt[34] dz[35], 40 | -
// One word per cycle sustained while the output is not stalled; once its input word
// leaves the queue, a result word passes 1 capture register, 64 divider stages
// (one quotient bit each) and 1 result register.
// Queue of 4 words decouples input from the pipeline; pipeline advances
// only when its output register is empty or being taken.
// Reset (rst, synchronous) clears queue pointers and stage valid bits.
module fixed_point_alu import fpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // command, operand_a, operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // result, less_than, equal, greater_than, divide_by_zero
);

  logic  q_valid, q_ready;
  item_t q_item;
  res_t  r;

  fpa_front u_front (
    .clk, .rst,
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tdata[2:0]),
    .in_a     (s_axis_tdata[34:3]),
    .in_b     (s_axis_tdata[66:35]),
    .q_valid, .q_ready, .q_item
  );

  fpa_back u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_item,
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (r)
  );

  assign m_axis_tdata = {4'b0, r.dz, r.gt, r.eq, r.lt, r.res};

endmodule
